### rtl/spvc_pkg.sv
// Shared types, constants and helper functions of the pressure/velocity correction block.
// No dependencies; every other file imports this package.
package spvc_pkg;

	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 4096;
	localparam int FRAC_BITS = 24;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int COLS_W = COL_W + 1;
	localparam int ROW_W  = $clog2(MAX_ROWS) + 1;

	localparam int CFG_COLS_W  = 9;
	localparam int CFG_ROWS_W  = 13;
	localparam int CFG_INV_W   = 32;
	localparam int CFG_RELAX_W = 17;
	localparam int CFG_IDX_W   = 3;
	localparam int DATA_W      = 32;

	localparam int GM_W   = 49;
	localparam int TERM_W = 41;
	localparam int SAT_W  = 48;

	localparam int MIDQ_DEPTH = 4;
	localparam int MIDQ_PTR_W = $clog2(MIDQ_DEPTH);
	localparam int MIDQ_CNT_W = $clog2(MIDQ_DEPTH + 1);

	localparam logic [CFG_COLS_W-1:0]  COLS_RESET  = 9'd256;
	localparam logic [CFG_ROWS_W-1:0]  ROWS_RESET  = 13'd256;
	localparam logic [CFG_INV_W-1:0]   INV_RESET   = 32'd65536;
	localparam logic [CFG_RELAX_W-1:0] RELAX_RESET = 17'd19661;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_COLS  = 3'd0,
		REG_GRID_ROWS  = 3'd1,
		REG_INV_TWO_DX = 3'd2,
		REG_INV_TWO_DY = 3'd3,
		REG_RELAX      = 3'd4
	} reg_index_t;

	typedef enum logic {
		CMD_CELL  = 1'b0,
		CMD_DRAIN = 1'b1
	} command_t;

	typedef enum logic {
		OP_SET_REF = 1'b0,
		OP_EMIT    = 1'b1
	} back_op_t;

	typedef struct packed {
		logic [CFG_COLS_W-1:0]  grid_cols;
		logic [CFG_ROWS_W-1:0]  grid_rows;
		logic [CFG_INV_W-1:0]   inv_two_dx;
		logic [CFG_INV_W-1:0]   inv_two_dy;
		logic [CFG_RELAX_W-1:0] relax_pressure;
	} cfg_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] us;
		logic signed [DATA_W-1:0] vs;
		logic signed [DATA_W-1:0] du;
		logic signed [DATA_W-1:0] dv;
		logic signed [DATA_W-1:0] po;
	} fields_t;

	typedef struct packed {
		back_op_t                 op;
		logic                     last;
		logic signed [DATA_W-1:0] u_star;
		logic signed [DATA_W-1:0] v_star;
		logic signed [DATA_W-1:0] u_fac;
		logic signed [DATA_W-1:0] v_fac;
		logic signed [DATA_W-1:0] p_base;
		logic signed [DATA_W-1:0] pc;
		logic signed [DATA_W:0]   diff_x;
		logic signed [DATA_W:0]   diff_y;
	} work_t;

	typedef struct packed {
		logic                     last;
		logic signed [DATA_W-1:0] u;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] p;
	} result_t;

	function automatic logic [COLS_W-1:0] eff_cols(input logic [CFG_COLS_W-1:0] g);
		if (g == '0)
			return COLS_W'(1);
		else if (int'(g) > MAX_COLS)
			return COLS_W'(MAX_COLS);
		else
			return COLS_W'(g);
	endfunction

	function automatic logic [ROW_W-1:0] eff_rows(input logic [CFG_ROWS_W-1:0] g);
		if (g == '0)
			return ROW_W'(1);
		else if (int'(g) > MAX_ROWS)
			return ROW_W'(MAX_ROWS);
		else
			return ROW_W'(g);
	endfunction

	function automatic logic [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
		logic signed [SAT_W-1:0] hi;
		logic signed [SAT_W-1:0] lo;
		hi = SAT_W'(64'sh7fff_ffff);
		lo = SAT_W'(-64'sh8000_0000);
		if (x > hi)
			return 32'h7fff_ffff;
		else if (x < lo)
			return 32'h8000_0000;
		else
			return x[DATA_W-1:0];
	endfunction

endpackage

### rtl/simple_pressure_velocity_correction.sv
// Top level of the streamed pressure and velocity correction block.
// Depends on spvc_pkg, spvc_front, spvc_queue and spvc_back.
//
//   channel   handshake          payload
//   ------    ---------------    ---------------------------------------------------
//   input     push / full        command, pc_value, u_predicted, v_predicted,
//                                u_factor, v_factor, p_old
//   result    empty / pop        u_new, v_new, p_new, last
//   config    cfg_wr_en          cfg_index, cfg_data
//
// The block takes one input beat per clock and sustains that rate while results are taken.
// A result passes from the accept edge through the front stage register, the middle queue,
// the back-end stages and the output queue. The line buffers are read at the accept edge,
// where center and field buffers are also written; the arithmetic is a four-stage pipeline.
// Reset is asynchronous; the line buffers need no clearing pass, so the block accepts
// beats right after reset. The back end stalls as a whole while its two-entry output
// queue is full, and full rises when the queue between front and back can take no more.
module simple_pressure_velocity_correction import spvc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] pc_value,
	input  logic signed [DATA_W-1:0] u_predicted,
	input  logic signed [DATA_W-1:0] v_predicted,
	input  logic signed [DATA_W-1:0] u_factor,
	input  logic signed [DATA_W-1:0] v_factor,
	input  logic signed [DATA_W-1:0] p_old,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] u_new,
	output logic signed [DATA_W-1:0] v_new,
	output logic signed [DATA_W-1:0] p_new,
	output logic                     last,
	input  logic                     cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]        cfg_data
);

	cfg_t                  cfg_q;
	work_t                 front_work, q_data;
	logic                  front_valid;
	logic                  q_empty, q_pop;
	logic [MIDQ_CNT_W-1:0] q_count;

	// Configuration registers. The user must do writes only while the block is idle; the block
	// itself does not enforce this; front and back read them directly without any shadowing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_cols      <= COLS_RESET;
			cfg_q.grid_rows      <= ROWS_RESET;
			cfg_q.inv_two_dx     <= INV_RESET;
			cfg_q.inv_two_dy     <= INV_RESET;
			cfg_q.relax_pressure <= RELAX_RESET;
		end else if (cfg_wr_en) begin
			unique case (reg_index_t'(cfg_index))
				REG_GRID_COLS:  cfg_q.grid_cols      <= cfg_data[CFG_COLS_W-1:0];
				REG_GRID_ROWS:  cfg_q.grid_rows      <= cfg_data[CFG_ROWS_W-1:0];
				REG_INV_TWO_DX: cfg_q.inv_two_dx     <= cfg_data[CFG_INV_W-1:0];
				REG_INV_TWO_DY: cfg_q.inv_two_dy     <= cfg_data[CFG_INV_W-1:0];
				REG_RELAX:      cfg_q.relax_pressure <= cfg_data[CFG_RELAX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front end classifies each beat: a cell of the first row only fills the line
	// buffers (and the very first cell also produces the reference pressure), later
	// cells and drains release the result of the cell one row above.
	spvc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.full        (full),
		.command     (command),
		.pc_value    (pc_value),
		.u_predicted (u_predicted),
		.v_predicted (v_predicted),
		.u_factor    (u_factor),
		.v_factor    (v_factor),
		.p_old       (p_old),
		.q_count     (q_count),
		.work_valid  (front_valid),
		.work        (front_work)
	);

	spvc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_valid),
		.wr_data (front_work),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty),
		.count   (q_count)
	);

	// The back end does all multiplications, rounding and saturation in order.
	spvc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.empty   (empty),
		.pop     (pop),
		.u_new   (u_new),
		.v_new   (v_new),
		.p_new   (p_new),
		.last    (last)
	);

endmodule

### rtl/spvc_front.sv
// Front end: accepts items, keeps the raster counters and the line buffers, forms the gradients.
// Depends on spvc_pkg.
module spvc_front import spvc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     push,
	output logic                     full,
	input  logic                     command,
	input  logic signed [DATA_W-1:0] pc_value,
	input  logic signed [DATA_W-1:0] u_predicted,
	input  logic signed [DATA_W-1:0] v_predicted,
	input  logic signed [DATA_W-1:0] u_factor,
	input  logic signed [DATA_W-1:0] v_factor,
	input  logic signed [DATA_W-1:0] p_old,
	input  logic [MIDQ_CNT_W-1:0]    q_count,
	output logic                     work_valid,
	output work_t                    work
);

	logic [COL_W-1:0]  col_q, drain_q;
	logic [ROW_W-1:0]  row_q;
	logic [COLS_W-1:0] cols;
	logic [ROW_W-1:0]  rows;

	logic accept, is_cell, cell_take, drain_take, emit, set_ref;
	logic col_wrap, drain_end;
	logic [COL_W-1:0]  c, c_next;
	logic [COLS_W-1:0] c_plus;

	logic [DATA_W-1:0] pc_center_mem [MAX_COLS];
	fields_t           fields_mem    [MAX_COLS];
	logic [DATA_W-1:0] above_mem     [MAX_COLS];
	logic [MAX_COLS-1:0] above_vld_q;

	logic                     s1_v_q;
	back_op_t                 op_s1;
	logic                     last_s1;
	logic [COL_W-1:0]         c_s1;
	logic                     has_left_s1, has_right_s1, has_above_s1;
	logic signed [DATA_W-1:0] below_s1, in_pc_s1, in_po_s1;
	logic signed [DATA_W-1:0] pcc_rd_s1, pcr_rd_s1, above_rd_s1;
	fields_t                  fld_rd_s1;
	logic signed [DATA_W-1:0] left_q;
	logic                     s1_writes_above;

	logic signed [DATA_W-1:0] left, right, above;

	assign cols = eff_cols(cfg.grid_cols);
	assign rows = eff_rows(cfg.grid_rows);

	// The front stage plus whatever sits in the queue must fit in the queue.
	assign full = ({1'b0, q_count} + (MIDQ_CNT_W+1)'(s1_v_q)) >= (MIDQ_CNT_W+1)'(MIDQ_DEPTH);

	assign accept     = push && !full;
	assign is_cell    = (command == CMD_CELL);
	assign cell_take  = accept && is_cell && (row_q < rows);
	assign drain_take = accept && !is_cell && (row_q >= rows) && (row_q != '0);
	assign emit       = (cell_take && (row_q != '0)) || drain_take;
	assign set_ref    = cell_take && (row_q == '0) && (col_q == '0);

	assign c        = is_cell ? col_q : drain_q;
	assign c_next   = c + 1'b1;
	assign c_plus   = {1'b0, c} + 1'b1;
	assign col_wrap = ({1'b0, col_q} + 1'b1) >= cols;
	assign drain_end = ({1'b0, drain_q} + 1'b1) >= cols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= '0;
		end else if (cell_take) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end else if (drain_take) begin
			if (drain_end) begin
				col_q   <= '0;
				row_q   <= '0;
				drain_q <= '0;
			end else begin
				drain_q <= drain_q + 1'b1;
			end
		end
	end

	assign s1_writes_above = s1_v_q && (op_s1 == OP_EMIT);

	// Line buffers: reads are registered; center and field reads see old data at a shared address, above reads bypass.
	always_ff @(posedge clk) begin
		if (cell_take) begin
			pc_center_mem[c] <= pc_value;
			fields_mem[c]    <= '{us: u_predicted, vs: v_predicted, du: u_factor,
			                      dv: v_factor, po: p_old};
		end
		if (accept) begin
			pcc_rd_s1 <= pc_center_mem[c];
			pcr_rd_s1 <= pc_center_mem[c_next];
			fld_rd_s1 <= fields_mem[c];
			if (s1_writes_above && (c_s1 == c))
				above_rd_s1 <= pcc_rd_s1;
			else if (above_vld_q[c])
				above_rd_s1 <= above_mem[c];
			else
				above_rd_s1 <= '0;
		end
		if (s1_writes_above)
			above_mem[c_s1] <= pcc_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_vld_q <= '0;
			s1_v_q      <= 1'b0;
		end else begin
			if (s1_writes_above)
				above_vld_q[c_s1] <= 1'b1;
			s1_v_q <= emit || set_ref;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1        <= emit ? OP_EMIT : OP_SET_REF;
			last_s1      <= drain_take && drain_end;
			c_s1         <= c;
			has_left_s1  <= (c != '0);
			has_right_s1 <= (c_plus < cols);
			has_above_s1 <= (row_q >= ROW_W'(2));
			below_s1     <= is_cell ? pc_value : '0;
			in_pc_s1     <= pc_value;
			in_po_s1     <= p_old;
		end
		// The left neighbor is the center value that the previous result moved up.
		if (s1_writes_above)
			left_q <= pcc_rd_s1;
	end

	assign left  = has_left_s1  ? left_q      : '0;
	assign right = has_right_s1 ? pcr_rd_s1   : '0;
	assign above = has_above_s1 ? above_rd_s1 : '0;

	assign work_valid = s1_v_q;

	always_comb begin
		work.op     = op_s1;
		work.last   = last_s1;
		work.u_star = fld_rd_s1.us;
		work.v_star = fld_rd_s1.vs;
		work.u_fac  = fld_rd_s1.du;
		work.v_fac  = fld_rd_s1.dv;
		work.p_base = (op_s1 == OP_SET_REF) ? in_po_s1 : fld_rd_s1.po;
		work.pc     = (op_s1 == OP_SET_REF) ? in_pc_s1 : pcc_rd_s1;
		work.diff_x = {right[DATA_W-1], right} - {left[DATA_W-1], left};
		work.diff_y = {below_s1[DATA_W-1], below_s1} - {above[DATA_W-1], above};
	end

endmodule

### rtl/spvc_queue.sv
// Short queue that decouples the front end from the arithmetic back end.
// Depends on spvc_pkg.
module spvc_queue import spvc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  work_t                 wr_data,
	input  logic                  rd_en,
	output work_t                 rd_data,
	output logic                  empty,
	output logic [MIDQ_CNT_W-1:0] count
);

	work_t                 mem [MIDQ_DEPTH];
	logic [MIDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [MIDQ_CNT_W-1:0] cnt_q;

	assign empty   = (cnt_q == '0);
	assign count   = cnt_q;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + MIDQ_CNT_W'(wr_en) - MIDQ_CNT_W'(rd_en);
		end
	end

endmodule

### rtl/spvc_back.sv
// Back end: gradient scaling, velocity correction, pressure relaxation and the result queue.
// Depends on spvc_pkg.
module spvc_back import spvc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  logic                     q_empty,
	input  work_t                    q_data,
	output logic                     q_pop,
	output logic                     empty,
	input  logic                     pop,
	output logic signed [DATA_W-1:0] u_new,
	output logic signed [DATA_W-1:0] v_new,
	output logic signed [DATA_W-1:0] p_new,
	output logic                     last
);

	logic en;

	// Stage 1: gradient and relaxation products.
	logic [DATA_W:0]     magx, magy;
	logic [2*DATA_W-1:0] prodx_raw, prody_raw;
	logic [DATA_W-1:0]   magpc;
	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q;
	back_op_t op_s1, op_s2, op_s3, op_s4;
	logic last_s1, last_s2, last_s3, last_s4;
	logic [2*DATA_W-1:0] prodx_s1, prody_s1;
	logic [DATA_W-1:0]   fmx_s1, fmy_s1, fmx_s2, fmy_s2;
	logic sgnx_s1, sgny_s1, sgnx_s2, sgny_s2, sgnx_s3, sgny_s3, sgnx_s4, sgny_s4;
	logic signed [DATA_W-1:0] us_s1, vs_s1, po_s1, us_s2, vs_s2, us_s3, vs_s3, us_s4, vs_s4;
	logic [DATA_W+CFG_RELAX_W-1:0] rprod_s1;
	logic pcneg_s1;

	// Stage 2
	logic [2*DATA_W:0]            rndx, rndy;
	logic [DATA_W+CFG_RELAX_W:0]  rndr;
	logic [DATA_W+1:0]            rmag;
	logic signed [SAT_W-1:0]      relax_sum;
	logic [GM_W-1:0]              gmx_s2, gmy_s2;
	logic signed [DATA_W-1:0]     relaxed_s2;

	// Stage 3
	logic signed [DATA_W-1:0]      ref_q;
	logic [2*DATA_W-1:0]           plox_s3, ploy_s3;
	logic [GM_W-1:0]               phix_s3, phiy_s3;
	logic signed [DATA_W-1:0]      pnew_s3, pnew_s4;

	// Stage 4
	logic [TERM_W-1:0] termx, termy, termx_s4, termy_s4;

	// Output queue of two entries.
	result_t out_mem [2];
	logic    out_wr_q, out_rd_q;
	logic [1:0] out_cnt_q;
	logic    out_push, out_pop;
	result_t res;

	function automatic logic [TERM_W-1:0] make_term(input logic [2*DATA_W-1:0] plo,
	                                                input logic [GM_W-1:0] phi);
		logic [2*DATA_W:0] full_sum;
		logic [2*DATA_W:0] rnd;
		logic [2*DATA_W:0] shifted;
		logic [2*DATA_W:0] clamp;
		clamp = (2*DATA_W+1)'(1) << (TERM_W - 1);
		full_sum = {2'b0, phi[DATA_W-2:0], {DATA_W{1'b0}}} + {1'b0, plo};
		rnd = full_sum + ((2*DATA_W+1)'(1) << (FRAC_BITS - 1));
		shifted = rnd >> FRAC_BITS;
		if (phi[GM_W-1:DATA_W-1] != '0)
			return clamp[TERM_W-1:0];
		else if (shifted > clamp)
			return clamp[TERM_W-1:0];
		else
			return shifted[TERM_W-1:0];
	endfunction

	assign en    = (out_cnt_q != 2'd2);
	assign q_pop = en && !q_empty;

	assign magx  = q_data.diff_x[DATA_W] ? (DATA_W+1)'(-q_data.diff_x) : q_data.diff_x;
	assign magy  = q_data.diff_y[DATA_W] ? (DATA_W+1)'(-q_data.diff_y) : q_data.diff_y;
	assign magpc = q_data.pc[DATA_W-1] ? DATA_W'(-q_data.pc) : q_data.pc;
	assign prodx_raw = magx[DATA_W-1:0] * cfg.inv_two_dx;
	assign prody_raw = magy[DATA_W-1:0] * cfg.inv_two_dy;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= q_data.op;
			last_s1  <= q_data.last;
			prodx_s1 <= magx[DATA_W] ? {cfg.inv_two_dx, {DATA_W{1'b0}}} : prodx_raw;
			prody_s1 <= magy[DATA_W] ? {cfg.inv_two_dy, {DATA_W{1'b0}}} : prody_raw;
			fmx_s1   <= q_data.u_fac[DATA_W-1] ? DATA_W'(-q_data.u_fac) : q_data.u_fac;
			fmy_s1   <= q_data.v_fac[DATA_W-1] ? DATA_W'(-q_data.v_fac) : q_data.v_fac;
			sgnx_s1  <= q_data.diff_x[DATA_W] ^ q_data.u_fac[DATA_W-1];
			sgny_s1  <= q_data.diff_y[DATA_W] ^ q_data.v_fac[DATA_W-1];
			us_s1    <= q_data.u_star;
			vs_s1    <= q_data.v_star;
			po_s1    <= q_data.p_base;
			rprod_s1 <= magpc * cfg.relax_pressure;
			pcneg_s1 <= q_data.pc[DATA_W-1];
		end
	end

	assign rndx = {1'b0, prodx_s1} + (2*DATA_W+1)'(32768);
	assign rndy = {1'b0, prody_s1} + (2*DATA_W+1)'(32768);
	assign rndr = {1'b0, rprod_s1} + (DATA_W+CFG_RELAX_W+1)'(32768);
	assign rmag = rndr[DATA_W+CFG_RELAX_W:16];
	assign relax_sum = pcneg_s1
		? SAT_W'(po_s1) - $signed({{(SAT_W-DATA_W-2){1'b0}}, rmag})
		: SAT_W'(po_s1) + $signed({{(SAT_W-DATA_W-2){1'b0}}, rmag});

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2      <= op_s1;
			last_s2    <= last_s1;
			gmx_s2     <= rndx[2*DATA_W:16];
			gmy_s2     <= rndy[2*DATA_W:16];
			fmx_s2     <= fmx_s1;
			fmy_s2     <= fmy_s1;
			sgnx_s2    <= sgnx_s1;
			sgny_s2    <= sgny_s1;
			us_s2      <= us_s1;
			vs_s2      <= vs_s1;
			relaxed_s2 <= sat32(relax_sum);
		end
	end

	// The reference pressure is written and read in this one stage, so items see it in order.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ref_q <= '0;
		else if (en && v_s2_q && (op_s2 == OP_SET_REF))
			ref_q <= relaxed_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3   <= op_s2;
			last_s3 <= last_s2;
			plox_s3 <= fmx_s2 * gmx_s2[DATA_W-1:0];
			phix_s3 <= fmx_s2 * gmx_s2[GM_W-1:DATA_W];
			ploy_s3 <= fmy_s2 * gmy_s2[DATA_W-1:0];
			phiy_s3 <= fmy_s2 * gmy_s2[GM_W-1:DATA_W];
			sgnx_s3 <= sgnx_s2;
			sgny_s3 <= sgny_s2;
			us_s3   <= us_s2;
			vs_s3   <= vs_s2;
			pnew_s3 <= sat32(SAT_W'(relaxed_s2) - SAT_W'(ref_q));
		end
	end

	assign termx = make_term(plox_s3, phix_s3);
	assign termy = make_term(ploy_s3, phiy_s3);

	always_ff @(posedge clk) begin
		if (en) begin
			op_s4    <= op_s3;
			last_s4  <= last_s3;
			termx_s4 <= termx;
			termy_s4 <= termy;
			sgnx_s4  <= sgnx_s3;
			sgny_s4  <= sgny_s3;
			us_s4    <= us_s3;
			vs_s4    <= vs_s3;
			pnew_s4  <= pnew_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
		end else if (en) begin
			v_s1_q <= q_pop;
			v_s2_q <= v_s1_q;
			v_s3_q <= v_s2_q;
			v_s4_q <= v_s3_q;
		end
	end

	always_comb begin
		res.last = last_s4;
		res.u = sgnx_s4 ? sat32(SAT_W'(us_s4) + $signed(SAT_W'(termx_s4)))
		                : sat32(SAT_W'(us_s4) - $signed(SAT_W'(termx_s4)));
		res.v = sgny_s4 ? sat32(SAT_W'(vs_s4) + $signed(SAT_W'(termy_s4)))
		                : sat32(SAT_W'(vs_s4) - $signed(SAT_W'(termy_s4)));
		res.p = pnew_s4;
	end

	assign out_push = en && v_s4_q && (op_s4 == OP_EMIT);
	assign out_pop  = pop && !empty;
	assign empty    = (out_cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (out_push)
			out_mem[out_wr_q] <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_wr_q  <= 1'b0;
			out_rd_q  <= 1'b0;
			out_cnt_q <= 2'd0;
		end else begin
			if (out_push)
				out_wr_q <= !out_wr_q;
			if (out_pop)
				out_rd_q <= !out_rd_q;
			out_cnt_q <= out_cnt_q + 2'(out_push) - 2'(out_pop);
		end
	end

	assign u_new = out_mem[out_rd_q].u;
	assign v_new = out_mem[out_rd_q].v;
	assign p_new = out_mem[out_rd_q].p;
	assign last  = out_mem[out_rd_q].last;

endmodule

### rtl/spvc_checker.sv
// Port-level checks of the correction block, attached by bind.
// Depends on spvc_pkg and simple_pressure_velocity_correction.
module spvc_checker import spvc_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     push,
	input logic                     full,
	input logic                     empty,
	input logic                     pop,
	input logic signed [DATA_W-1:0] u_new,
	input logic signed [DATA_W-1:0] v_new,
	input logic signed [DATA_W-1:0] p_new,
	input logic                     last
);

	// Right after reset both queues are clear.
	a_reset_clear: assert property (@(posedge clk) $rose(arst_n) |-> (empty && !full))
		else $error("queues not clear after reset");

	// Full can only rise as a consequence of an accepted beat.
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!full && !push) |=> !full)
		else $error("full rose without an accepted input beat");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("waiting result withdrawn");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(u_new) && $stable(v_new) && $stable(p_new)
			&& $stable(last)))
		else $error("waiting result changed");

endmodule

bind simple_pressure_velocity_correction spvc_checker u_spvc_checker (.*);

### verif/tb.sv
// Testbench for the streamed pressure and velocity correction block.
// Depends on spvc_pkg and the RTL top level simple_pressure_velocity_correction.
module tb;
	import spvc_pkg::*;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     push = 1'b0;
	logic                     full;
	logic                     command = CMD_CELL;
	logic signed [DATA_W-1:0] pc_value = '0;
	logic signed [DATA_W-1:0] u_predicted = '0;
	logic signed [DATA_W-1:0] v_predicted = '0;
	logic signed [DATA_W-1:0] u_factor = '0;
	logic signed [DATA_W-1:0] v_factor = '0;
	logic signed [DATA_W-1:0] p_old = '0;
	logic                     empty;
	logic                     pop = 1'b0;
	logic signed [DATA_W-1:0] u_new;
	logic signed [DATA_W-1:0] v_new;
	logic signed [DATA_W-1:0] p_new;
	logic                     last;
	logic                     cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_GRID_COLS;
	logic [DATA_W-1:0]        cfg_data = '0;

	simple_pressure_velocity_correction dut (.*);

	always #5 clk = ~clk;

	// Shadow copy of the configuration and of the stencil state. The block lags one
	// row, so each cell beat from row 1 on completes the result of the cell above it.
	logic [CFG_COLS_W-1:0]  cols_reg;
	logic [CFG_ROWS_W-1:0]  rows_reg;
	logic [31:0]            inv_dx, inv_dy;
	logic [CFG_RELAX_W-1:0] relax;
	logic [31:0]            pc_prev_row [MAX_COLS];
	logic [31:0]            pc_cur_row [MAX_COLS];
	fields_t                cur_fields [MAX_COLS];
	int                     col_pos, row_pos, flush_pos;
	logic [31:0]            ref_press;
	bit                     ref_held;

	result_t                pending_results [$];
	int                     error_count = 0;
	int                     beats_sent = 0;
	int                     burst_left = 0;

	function automatic int cols_in_use();
		if (cols_reg == 0)
			return 1;
		return (int'(cols_reg) > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	function automatic int rows_in_use();
		if (rows_reg == 0)
			return 1;
		return (int'(rows_reg) > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic longint sext(logic [31:0] w);
		return longint'($signed(w));
	endfunction

	function automatic longint clamp32(longint x);
		if (x > 64'sd2147483647)
			return 64'sd2147483647;
		if (x < -64'sd2147483648)
			return -64'sd2147483648;
		return x;
	endfunction

	function automatic logic [63:0] magnitude(longint x);
		return (x < 0) ? (64'd0 - 64'(x)) : 64'(x);
	endfunction

	// base - factor * diff * inv. The gradient is rounded to unsigned Q25.24 first, the
	// correction term is rounded, capped at 2^40 and then applied with its sign.
	function automatic logic [31:0] corrected_velocity(longint base, longint factor,
			longint diff, logic [31:0] inv);
		logic [63:0] grad, fm, lo_part, hi_part, whole, term;
		grad = (magnitude(diff) * 64'(inv) + 64'd32768) >> 16;
		fm = magnitude(factor);
		lo_part = fm * (grad & 64'hffff_ffff);
		hi_part = fm * (grad >> 32);
		if (hi_part >= 64'h8000_0000) begin
			term = 64'd1 << 40;
		end else begin
			whole = (hi_part << 32) + lo_part;
			term = (whole + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (term > (64'd1 << 40))
				term = 64'd1 << 40;
		end
		if ((diff < 0) != (factor < 0))
			return 32'(clamp32(base + longint'(term)));
		return 32'(clamp32(base - longint'(term)));
	endfunction

	function automatic longint relaxed_pressure(longint p, longint pc);
		longint r;
		r = longint'((magnitude(pc) * 64'(relax) + 64'd32768) >> 16);
		return clamp32(p + ((pc < 0) ? -r : r));
	endfunction

	// Result of the cell in column c of the row held in the center buffer.
	function automatic result_t finish_cell(int c, longint below);
		result_t res;
		longint left, right, above, pc, refp;
		int cols;
		cols = cols_in_use();
		left = (c >= 1) ? sext(pc_prev_row[c-1]) : 0;
		right = (c + 1 < cols) ? sext(pc_cur_row[c+1]) : 0;
		above = (row_pos >= 2) ? sext(pc_prev_row[c]) : 0;
		pc = sext(pc_cur_row[c]);
		refp = ref_held ? sext(ref_press) : 0;
		res.u = corrected_velocity(sext(cur_fields[c].us), sext(cur_fields[c].du),
			right - left, inv_dx);
		res.v = corrected_velocity(sext(cur_fields[c].vs), sext(cur_fields[c].dv),
			below - above, inv_dy);
		res.p = 32'(clamp32(relaxed_pressure(sext(cur_fields[c].po), pc) - refp));
		res.last = 1'b0;
		pc_prev_row[c] = pc_cur_row[c];
		return res;
	endfunction

	// Appends one predicted result behind the ones already waiting.
	function automatic void add_expected(result_t r);
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Advances the shadow state by one accepted beat and queues what it produces.
	function automatic void predict_beat(command_t cmd, logic [31:0] pc, fields_t f);
		result_t res;
		if (cmd == CMD_CELL) begin
			if (row_pos >= rows_in_use())
				return;
			if (row_pos >= 1)
				add_expected(finish_cell(col_pos, sext(pc)));
			pc_cur_row[col_pos] = pc;
			cur_fields[col_pos] = f;
			if (row_pos == 0 && col_pos == 0) begin
				ref_press = 32'(relaxed_pressure(sext(f.po), sext(pc)));
				ref_held = 1'b1;
			end
			col_pos++;
			if (col_pos >= cols_in_use()) begin
				col_pos = 0;
				row_pos++;
			end
		end else begin
			if (row_pos < rows_in_use() || row_pos == 0)
				return;
			res = finish_cell(flush_pos, 0);
			flush_pos++;
			if (flush_pos >= cols_in_use()) begin
				res.last = 1'b1;
				col_pos = 0;
				row_pos = 0;
				flush_pos = 0;
				ref_press = '0;
				ref_held = 1'b0;
			end
			add_expected(res);
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	// Result checker: every popped beat is matched against the oldest prediction.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result beat", {u_new}, 32'h0);
			end else begin
				want = pending_results.pop_front();
				if (u_new !== want.u)
					report_mismatch("u_new", u_new, want.u);
				if (v_new !== want.v)
					report_mismatch("v_new", v_new, want.v);
				if (p_new !== want.p)
					report_mismatch("p_new", p_new, want.p);
				if (last !== want.last)
					report_mismatch("last", 32'(last), 32'(want.last));
			end
		end
	end

	// The receiver switches between no stalls, light stalls and heavy stalls, holding each
	// level for a random stretch, so that back pressure meets every pipeline phase.
	int stall_pct = 0;
	int stall_age = 0;
	always @(posedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pct = 0;
				1: stall_pct = 25;
				2: stall_pct = 60;
				default: stall_pct = 90;
			endcase
			stall_age = $urandom_range(50, 300);
		end
		stall_age--;
		pop <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0;
			3: return 32'hffff_ffff;
			4: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
			default: return $urandom();
		endcase
	endfunction

	// Sends one beat. The sender works in bursts; push only drops between bursts,
	// so a beat that follows directly keeps push high across the edge.
	task automatic send_beat(command_t cmd, logic [31:0] pc, fields_t f);
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		push <= 1'b1;
		command <= cmd;
		pc_value <= pc;
		u_predicted <= f.us;
		v_predicted <= f.vs;
		u_factor <= f.du;
		v_factor <= f.dv;
		p_old <= f.po;
		@(posedge clk);
		while (full)
			@(posedge clk);
		predict_beat(cmd, pc, f);
		beats_sent++;
	endtask

	task automatic send_random_cell();
		fields_t f;
		f = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
		send_beat(CMD_CELL, pick_word(), f);
	endtask

	// Registers change only while nothing is in flight; the extra cycles cover a
	// beat still inside the pipeline after the last result has left.
	task automatic write_reg(reg_index_t idx, logic [31:0] value);
		push <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_GRID_COLS: cols_reg = value[CFG_COLS_W-1:0];
			REG_GRID_ROWS: rows_reg = value[CFG_ROWS_W-1:0];
			REG_INV_TWO_DX: inv_dx = value;
			REG_INV_TWO_DY: inv_dy = value;
			default: relax = value[CFG_RELAX_W-1:0];
		endcase
	endtask

	task automatic set_config(int cols, int rows, logic [31:0] dx, logic [31:0] dy,
			logic [31:0] rp);
		write_reg(REG_GRID_COLS, cols);
		write_reg(REG_GRID_ROWS, rows);
		write_reg(REG_INV_TWO_DX, dx);
		write_reg(REG_INV_TWO_DY, dy);
		write_reg(REG_RELAX, rp);
	endtask

	// One whole frame of random cells plus its flush. With noise_pct above zero,
	// drains that arrive too early and cells that arrive after the grid is full
	// are mixed in; the block must ignore both.
	task automatic run_frame(int noise_pct);
		fields_t f;
		int n_cells;
		n_cells = cols_in_use() * rows_in_use();
		for (int i = 0; i < n_cells; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				f = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
				send_beat(CMD_DRAIN, pick_word(), f);
			end
			send_random_cell();
		end
		if ($urandom_range(0, 99) < noise_pct)
			send_random_cell();
		for (int i = 0; i < cols_in_use(); i++) begin
			f = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
			send_beat(CMD_DRAIN, pick_word(), f);
		end
	endtask

	// Saturating extremes on a 3 by 3 grid, with the largest gradient scales and
	// a relaxation factor of one, plus an early drain and a cell past the grid.
	task automatic test_extreme_fields();
		fields_t f;
		logic [31:0] corner [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
		set_config(3, 3, 32'hffff_ffff, 32'hffff_ffff, 32'd65536);
		f = {corner[0], corner[1], corner[1], corner[0], corner[1]};
		send_beat(CMD_DRAIN, corner[1], f);
		for (int i = 0; i < 9; i++) begin
			f = {corner[i % 4], corner[(i + 1) % 4], corner[(i + 2) % 4],
				corner[(i + 3) % 4], corner[i % 4]};
			send_beat(CMD_CELL, corner[(i * 3) % 4], f);
		end
		send_beat(CMD_CELL, corner[1], f);
		for (int i = 0; i < 3; i++)
			send_beat(CMD_DRAIN, corner[0], f);
	endtask

	// Out-of-range and extreme grid sizes; the first frame uses zero scales and zero relaxation.
	task automatic test_grid_sizes();
		set_config(0, 0, 0, 0, 0);
		run_frame(0);
		set_config(511, 2, 32'd65536, 32'h0001_8000, 32'd19661);
		run_frame(0);
		set_config(1, 200, 32'h00ff_ffff, 32'd65536, 32'd65535);
		run_frame(0);
		set_config(256, 1, 32'd65536, 32'd65536, 32'd65536);
		run_frame(0);
	endtask

	// Random frames, mostly small, with random scales and a little noise.
	task automatic test_random_frames();
		int start;
		start = beats_sent;
		while (beats_sent - start < 450) begin
			set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 40)
				: $urandom_range(1, 8), $urandom_range(1, 7),
				($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20),
				($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 1 << 20),
				$urandom_range(0, 65536));
			run_frame(5);
		end
	endtask

	initial begin
		cols_reg = COLS_RESET;
		rows_reg = ROWS_RESET;
		inv_dx = INV_RESET;
		inv_dy = INV_RESET;
		relax = RELAX_RESET;
		foreach (pc_prev_row[i])
			pc_prev_row[i] = '0;
		col_pos = 0;
		row_pos = 0;
		flush_pos = 0;
		ref_press = '0;
		ref_held = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_fields();
		test_grid_sizes();
		test_random_frames();
		push <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

### files.f
rtl/spvc_pkg.sv
rtl/spvc_front.sv
rtl/spvc_queue.sv
rtl/spvc_back.sv
rtl/simple_pressure_velocity_correction.sv
rtl/spvc_checker.sv
verif/tb.sv
